// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the SPH kernel block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPHK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sphk assertion failed");

// Next-cycle implication, disabled during reset
`define SPHK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sphk assertion failed");

`endif

// ===== rtl/sphk_pkg.sv =====
// Package for the SPH cubic spline kernel: widths, register indexes, reset values
// and the item structs. No dependencies.
`default_nettype none

package sphk_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_BITS     = 32;
    localparam int SCALE_BITS    = 63;
    localparam int DIM_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIMENSIONS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORM_1D    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORM_2D    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORM_3D    = 2'd3;

    // reset values
    localparam logic [DIM_BITS-1:0]  DIMS_RESET = 2'd3;
    localparam logic [NORM_BITS-1:0] NORM_1D_RESET = 32'd715827883;
    localparam logic [NORM_BITS-1:0] NORM_2D_RESET = 32'd488260911;
    localparam logic [NORM_BITS-1:0] NORM_3D_RESET = 32'd341782638;

    typedef struct packed {
        logic        [WORD_BITS-1:0] distance;
        logic        [WORD_BITS-1:0] smoothing_length;
        logic signed [WORD_BITS-1:0] coord_self;
        logic signed [WORD_BITS-1:0] coord_other;
    } t_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] kernel_value;
        logic signed [WORD_BITS-1:0] kernel_slope;
        logic signed [WORD_BITS-1:0] gradient_part;
        logic                        bad_length;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/sphk_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with a
// saturating quotient, optional bypass and a side bus. No dependencies.
`default_nettype none

module sphk_div #(
    parameter int NUM_BITS  = 32,
    parameter int SHIFT     = 16,
    parameter int DEN_BITS  = 32,
    parameter int QUO_BITS  = 63,
    parameter int SIDE_BITS = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [NUM_BITS-1:0]  i_num,
    input  wire logic [DEN_BITS-1:0]  i_den,
    input  wire logic                 i_bypass,
    input  wire logic [SIDE_BITS-1:0] i_side,
    output logic                      o_valid,
    output logic [QUO_BITS-1:0]       o_quo,
    output logic [SIDE_BITS-1:0]      o_side
);

    localparam int N = NUM_BITS + SHIFT;

    logic                 r_valid [N];
    logic [DEN_BITS-1:0]  r_rem   [N];
    logic [QUO_BITS-1:0]  r_quo   [N];
    logic                 r_ovf   [N];
    logic [NUM_BITS-1:0]  r_num   [N];
    logic [DEN_BITS-1:0]  r_den   [N];
    logic                 r_byp   [N];
    logic [SIDE_BITS-1:0] r_side  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                 p_valid;
        logic [DEN_BITS-1:0]  p_rem;
        logic [QUO_BITS-1:0]  p_quo;
        logic                 p_ovf;
        logic [NUM_BITS-1:0]  p_num;
        logic [DEN_BITS-1:0]  p_den;
        logic                 p_byp;
        logic [SIDE_BITS-1:0] p_side;
        logic                 n_bit;
        logic [DEN_BITS:0]    n_sh;
        logic [DEN_BITS:0]    n_diff;
        logic                 n_ge;

        // previous stage, or the inputs for the first step
        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_quo   = '0;
            assign p_ovf   = 1'b0;
            assign p_num   = i_num;
            assign p_den   = i_den;
            assign p_byp   = i_bypass;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_quo   = r_quo[k-1];
            assign p_ovf   = r_ovf[k-1];
            assign p_num   = r_num[k-1];
            assign p_den   = r_den[k-1];
            assign p_byp   = r_byp[k-1];
            assign p_side  = r_side[k-1];
        end

        // dividend bit for this step, MSB first; the shifted-in low bits are zero
        if (N - 1 - k >= SHIFT) begin : g_num_bit
            assign n_bit = p_num[N-1-k-SHIFT];
        end else begin : g_zero_bit
            assign n_bit = 1'b0;
        end

        // one restoring step
        always_comb begin
            n_sh   = {p_rem, n_bit};
            n_diff = n_sh - {1'b0, p_den};
            n_ge   = (n_sh >= {1'b0, p_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[DEN_BITS-1:0] : n_sh[DEN_BITS-1:0];
                r_quo[k]  <= {p_quo[QUO_BITS-2:0], n_ge};
                r_ovf[k]  <= p_ovf | p_quo[QUO_BITS-1];
                r_num[k]  <= p_num;
                r_den[k]  <= p_den;
                r_byp[k]  <= p_byp;
                r_side[k] <= p_side;
            end
        end
    end

    // bypass passes the dividend through; otherwise saturate on any quotient bit shifted out at the top
    always_comb begin
        o_valid = r_valid[N-1];
        o_side  = r_side[N-1];
        if (r_byp[N-1]) begin
            o_quo = QUO_BITS'(r_num[N-1]);
        end else if (r_ovf[N-1]) begin
            o_quo = '1;
        end else begin
            o_quo = r_quo[N-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sph_cubic_spline_kernel.sv =====
// The pipeline runs through a chain of bit-per-stage dividers: scale by h (up to three times),
// q = r/h, gradient by r and by h.
// One item per cycle is taken while o_stall is low; an output register plus a one-entry skid
// stage hold results while the receiver stalls.
// Reset: synchronous active-low; clears valid bits and loads the register reset values.
// Depends on sphk_pkg, sphk_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sph_cubic_spline_kernel #(
    parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sphk_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [sphk_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire sphk_pkg::t_in                      i_data,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output sphk_pkg::t_out                          o_data
);

    import sphk_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SW  = SCALE_BITS;
    localparam int SHI = SW - 32;
    localparam int XW  = F + 2;
    localparam int PB  = F + 7;
    localparam int LW  = SW + PB;
    localparam int LO  = W / 2;
    localparam int HI  = W - LO;

    localparam logic [XW-1:0] TWO_Q  = {2'b10, {F{1'b0}}};
    localparam logic [PB-1:0] FOUR_Q = {{(PB-F-3){1'b0}}, 3'b100, {F{1'b0}}};
    localparam logic [LW-1:0] HALF   = LW'(1) << (W - 1);

    typedef struct packed {
        logic [W-1:0] r;
        logic [W-1:0] h;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [1:0]   dsel;
    } t_sa;

    typedef struct packed {
        logic [SW-1:0] s;
        logic [W-1:0]  r;
        logic [W-1:0]  h;
        logic [W-1:0]  a;
        logic [W-1:0]  b;
    } t_sq;

    typedef struct packed {
        logic [W-1:0] w;
        logic [W-1:0] s;
        logic [W-1:0] h;
        logic         gneg;
        logic         gen;
        logic         bad;
    } t_sr;

    typedef struct packed {
        logic [W-1:0] w;
        logic [W-1:0] s;
        logic         gneg;
        logic         gen;
        logic         bad;
    } t_sh;

    // clamp a magnitude with sign into a signed word
    function automatic logic [W-1:0] f_sat(input logic neg, input logic [LW-1:0] mag);
        logic [LW-1:0] m;
        if (neg) begin
            m = (mag > HALF) ? HALF : mag;
            m = '0 - m;
        end else begin
            m = (mag > HALF - LW'(1)) ? (HALF - LW'(1)) : mag;
        end
        return m[W-1:0];
    endfunction

    logic w_en;

    // configuration registers
    logic [DIM_BITS-1:0]  r_dims;
    logic [NORM_BITS-1:0] r_nf1, r_nf2, r_nf3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RESET;
            r_nf1  <= NORM_1D_RESET;
            r_nf2  <= NORM_2D_RESET;
            r_nf3  <= NORM_3D_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIMENSIONS: r_dims <= i_cfg_data[DIM_BITS-1:0];
                CFG_NORM_1D:    r_nf1  <= i_cfg_data[NORM_BITS-1:0];
                CFG_NORM_2D:    r_nf2  <= i_cfg_data[NORM_BITS-1:0];
                CFG_NORM_3D:    r_nf3  <= i_cfg_data[NORM_BITS-1:0];
                default:        r_dims <= r_dims;
            endcase
        end
    end

    // input stage: dimension select and factor pick
    logic                 r0_valid;
    logic [W-1:0]         r0_r, r0_h, r0_a, r0_b;
    logic [1:0]           r0_dsel;
    logic [NORM_BITS-1:0] r0_fac;
    logic [1:0]           n0_dsel;
    logic [NORM_BITS-1:0] n0_fac;

    always_comb begin
        n0_dsel = (r_dims == 2'd0) ? 2'd1 : r_dims;
        priority if (n0_dsel == 2'd1) begin
            n0_fac = r_nf1;
        end else if (n0_dsel == 2'd2) begin
            n0_fac = r_nf2;
        end else begin
            n0_fac = r_nf3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_r    <= i_data.distance;
            r0_h    <= i_data.smoothing_length;
            r0_a    <= i_data.coord_self;
            r0_b    <= i_data.coord_other;
            r0_dsel <= n0_dsel;
            r0_fac  <= n0_fac;
        end
    end

    // scale chain: factor / h per dimension
    t_sa           s0_sd, d1_sd, d2_sd, d3_sd;
    logic          d1_valid, d2_valid, d3_valid;
    logic [SW-1:0] d1_quo, d2_quo, d3_quo;

    assign s0_sd = '{r: r0_r, h: r0_h, a: r0_a, b: r0_b, dsel: r0_dsel};

    sphk_div #(
        .NUM_BITS(NORM_BITS), .SHIFT(F), .DEN_BITS(W), .QUO_BITS(SW),
        .SIDE_BITS($bits(t_sa))
    ) u_div_s1 (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(r0_valid), .i_num(r0_fac), .i_den(r0_h), .i_bypass(1'b0),
        .i_side(s0_sd), .o_valid(d1_valid), .o_quo(d1_quo), .o_side(d1_sd)
    );

    sphk_div #(
        .NUM_BITS(SW), .SHIFT(F), .DEN_BITS(W), .QUO_BITS(SW),
        .SIDE_BITS($bits(t_sa))
    ) u_div_s2 (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(d1_valid), .i_num(d1_quo), .i_den(d1_sd.h),
        .i_bypass(d1_sd.dsel < 2'd2),
        .i_side(d1_sd), .o_valid(d2_valid), .o_quo(d2_quo), .o_side(d2_sd)
    );

    sphk_div #(
        .NUM_BITS(SW), .SHIFT(F), .DEN_BITS(W), .QUO_BITS(SW),
        .SIDE_BITS($bits(t_sa))
    ) u_div_s3 (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(d2_valid), .i_num(d2_quo), .i_den(d2_sd.h),
        .i_bypass(d2_sd.dsel < 2'd3),
        .i_side(d2_sd), .o_valid(d3_valid), .o_quo(d3_quo), .o_side(d3_sd)
    );

    // q = r / h in Q.F
    t_sq           dq_in, dq_sd;
    logic          dq_valid;
    logic [XW-1:0] dq_quo;

    assign dq_in = '{s: d3_quo, r: d3_sd.r, h: d3_sd.h, a: d3_sd.a, b: d3_sd.b};

    sphk_div #(
        .NUM_BITS(W), .SHIFT(F), .DEN_BITS(W), .QUO_BITS(XW),
        .SIDE_BITS($bits(t_sq))
    ) u_div_q (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(d3_valid), .i_num(d3_sd.r), .i_den(d3_sd.h), .i_bypass(1'b0),
        .i_side(dq_in), .o_valid(dq_valid), .o_quo(dq_quo), .o_side(dq_sd)
    );

    // stage 1: region flags, polynomial base (q or 2 - q)
    logic          r1_valid, r1_bad, r1_insup, r1_reg2, r1_rz;
    logic [XW-1:0] r1_x;
    logic [SW-1:0] r1_s;
    logic [W-1:0]  r1_r, r1_h, r1_a, r1_b;
    logic          n1_reg2;

    assign n1_reg2 = (dq_sd.r >= dq_sd.h);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bad   <= (dq_sd.h == '0);
            r1_insup <= ({1'b0, dq_sd.r} < {dq_sd.h, 1'b0});
            r1_reg2  <= n1_reg2;
            r1_rz    <= (dq_sd.r == '0);
            r1_x     <= n1_reg2 ? (TWO_Q - dq_quo) : dq_quo;
            r1_s     <= dq_sd.s;
            r1_r     <= dq_sd.r;
            r1_h     <= dq_sd.h;
            r1_a     <= dq_sd.a;
            r1_b     <= dq_sd.b;
        end
    end

    // stage 2: square
    logic            r2_valid, r2_bad, r2_insup, r2_reg2, r2_rz;
    logic [XW-1:0]   r2_x, r2_x2;
    logic [SW-1:0]   r2_s;
    logic [W-1:0]    r2_r, r2_h, r2_a, r2_b;
    logic [2*XW-1:0] n2_sq;

    assign n2_sq = r1_x * r1_x;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_bad   <= r1_bad;
            r2_insup <= r1_insup;
            r2_reg2  <= r1_reg2;
            r2_rz    <= r1_rz;
            r2_x     <= r1_x;
            r2_x2    <= n2_sq[F+XW-1:F];
            r2_s     <= r1_s;
            r2_r     <= r1_r;
            r2_h     <= r1_h;
            r2_a     <= r1_a;
            r2_b     <= r1_b;
        end
    end

    // stage 3: cube
    logic            r3_valid, r3_bad, r3_insup, r3_reg2, r3_rz;
    logic [XW-1:0]   r3_x, r3_x2, r3_x3;
    logic [SW-1:0]   r3_s;
    logic [W-1:0]    r3_r, r3_h, r3_a, r3_b;
    logic [2*XW-1:0] n3_cu;

    assign n3_cu = r2_x2 * r2_x;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_bad   <= r2_bad;
            r3_insup <= r2_insup;
            r3_reg2  <= r2_reg2;
            r3_rz    <= r2_rz;
            r3_x     <= r2_x;
            r3_x2    <= r2_x2;
            r3_x3    <= n3_cu[F+XW-1:F];
            r3_s     <= r2_s;
            r3_r     <= r2_r;
            r3_h     <= r2_h;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
        end
    end

    // stage 4: polynomials at four times their value, split into sign and magnitude
    logic          r4_valid, r4_bad, r4_insup, r4_rz, r4_pn, r4_sn;
    logic [PB-1:0] r4_pm, r4_sm;
    logic [SW-1:0] r4_s;
    logic [W-1:0]  r4_r, r4_h, r4_a, r4_b;
    logic [PB-1:0] n4_x, n4_x2, n4_x3, n4_p, n4_sl;

    always_comb begin
        n4_x  = PB'(r3_x);
        n4_x2 = PB'(r3_x2);
        n4_x3 = PB'(r3_x3);
        if (r3_reg2) begin
            n4_p  = n4_x3;
            n4_sl = '0 - ((n4_x2 << 1) + n4_x2);
        end else begin
            n4_p  = FOUR_Q - ((n4_x2 << 2) + (n4_x2 << 1)) + ((n4_x3 << 1) + n4_x3);
            n4_sl = ((n4_x2 << 3) + n4_x2) - ((n4_x << 3) + (n4_x << 2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_bad   <= r3_bad;
            r4_insup <= r3_insup;
            r4_rz    <= r3_rz;
            r4_pn    <= n4_p[PB-1];
            r4_pm    <= n4_p[PB-1] ? ('0 - n4_p) : n4_p;
            r4_sn    <= n4_sl[PB-1];
            r4_sm    <= n4_sl[PB-1] ? ('0 - n4_sl) : n4_sl;
            r4_s     <= r3_s;
            r4_r     <= r3_r;
            r4_h     <= r3_h;
            r4_a     <= r3_a;
            r4_b     <= r3_b;
        end
    end

    // stage 5: scale times magnitude, as two partial products each
    logic              r5_valid, r5_bad, r5_insup, r5_rz, r5_pn, r5_sn;
    logic [32+PB-1:0]  r5_wl, r5_sl;
    logic [SHI+PB-1:0] r5_wh, r5_sh;
    logic [W-1:0]      r5_r, r5_h, r5_a, r5_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_bad   <= r4_bad;
            r5_insup <= r4_insup;
            r5_rz    <= r4_rz;
            r5_pn    <= r4_pn;
            r5_sn    <= r4_sn;
            r5_wl    <= r4_s[31:0] * r4_pm;
            r5_wh    <= r4_s[SW-1:32] * r4_pm;
            r5_sl    <= r4_s[31:0] * r4_sm;
            r5_sh    <= r4_s[SW-1:32] * r4_sm;
            r5_r     <= r4_r;
            r5_h     <= r4_h;
            r5_a     <= r4_a;
            r5_b     <= r4_b;
        end
    end

    // stage 6: combine partial products
    logic          r6_valid, r6_bad, r6_insup, r6_rz, r6_pn, r6_sn;
    logic [LW-1:0] r6_w, r6_s;
    logic [W-1:0]  r6_r, r6_h, r6_a, r6_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_bad   <= r5_bad;
            r6_insup <= r5_insup;
            r6_rz    <= r5_rz;
            r6_pn    <= r5_pn;
            r6_sn    <= r5_sn;
            r6_w     <= LW'(r5_wl) + (LW'(r5_wh) << 32);
            r6_s     <= LW'(r5_sl) + (LW'(r5_sh) << 32);
            r6_r     <= r5_r;
            r6_h     <= r5_h;
            r6_a     <= r5_a;
            r6_b     <= r5_b;
        end
    end

    // stage 7: drop 32 fraction bits, saturate, apply region and zero-length rules
    logic         r7_valid, r7_bad, r7_rz;
    logic [W-1:0] r7_w, r7_s, r7_r, r7_h, r7_a, r7_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_bad <= r6_bad;
            r7_rz  <= r6_rz;
            r7_w   <= (r6_bad || !r6_insup) ? '0 : f_sat(r6_pn, LW'(r6_w[LW-1:32]));
            r7_s   <= (r6_bad || !r6_insup || r6_rz) ? '0
                      : f_sat(r6_sn, LW'(r6_s[LW-1:32]));
            r7_r   <= r6_r;
            r7_h   <= r6_h;
            r7_a   <= r6_a;
            r7_b   <= r6_b;
        end
    end

    // stage 8: slope and coordinate difference magnitudes
    logic         r8_valid, r8_bad, r8_gneg, r8_gen;
    logic [W-1:0] r8_w, r8_s, r8_r, r8_h, r8_smag, r8_dmag;
    logic [W:0]   n8_diff, n8_ndiff;
    logic [W-1:0] n8_nslope;

    always_comb begin
        n8_diff   = {r7_a[W-1], r7_a} - {r7_b[W-1], r7_b};
        n8_ndiff  = '0 - n8_diff;
        n8_nslope = '0 - r7_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_bad  <= r7_bad;
            r8_gneg <= r7_s[W-1] ^ n8_diff[W];
            r8_gen  <= !r7_rz && (r7_s != '0);
            r8_w    <= r7_w;
            r8_s    <= r7_s;
            r8_r    <= r7_r;
            r8_h    <= r7_h;
            r8_smag <= r7_s[W-1] ? n8_nslope : r7_s;
            r8_dmag <= n8_diff[W] ? n8_ndiff[W-1:0] : n8_diff[W-1:0];
        end
    end

    // stage 9: |slope| * |xi - xj|, two partial products
    logic            r9_valid, r9_bad, r9_gneg, r9_gen;
    logic [W-1:0]    r9_w, r9_s, r9_r, r9_h;
    logic [W+LO-1:0] r9_pl;
    logic [W+HI-1:0] r9_ph;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_bad  <= r8_bad;
            r9_gneg <= r8_gneg;
            r9_gen  <= r8_gen;
            r9_w    <= r8_w;
            r9_s    <= r8_s;
            r9_r    <= r8_r;
            r9_h    <= r8_h;
            r9_pl   <= r8_smag * r8_dmag[LO-1:0];
            r9_ph   <= r8_smag * r8_dmag[W-1:LO];
        end
    end

    // stage 10: full product
    logic           r10_valid, r10_bad, r10_gneg, r10_gen;
    logic [W-1:0]   r10_w, r10_s, r10_r, r10_h;
    logic [2*W-1:0] r10_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_bad  <= r9_bad;
            r10_gneg <= r9_gneg;
            r10_gen  <= r9_gen;
            r10_w    <= r9_w;
            r10_s    <= r9_s;
            r10_r    <= r9_r;
            r10_h    <= r9_h;
            r10_prod <= (2*W)'(r9_pl) + ((2*W)'(r9_ph) << LO);
        end
    end

    // valid bits of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid  <= dq_valid;
            r2_valid  <= r1_valid;
            r3_valid  <= r2_valid;
            r4_valid  <= r3_valid;
            r5_valid  <= r4_valid;
            r6_valid  <= r5_valid;
            r7_valid  <= r6_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
        end
    end

    // gradient: product / r, then * 2^F / h
    t_sr           dr_in, dr_sd;
    t_sh           dh_in, dh_sd;
    logic          dr_valid, dh_valid;
    logic [SW-1:0] dr_quo;
    logic [W-1:0]  dh_quo;

    assign dr_in = '{w: r10_w, s: r10_s, h: r10_h, gneg: r10_gneg, gen: r10_gen,
                     bad: r10_bad};

    sphk_div #(
        .NUM_BITS(2*W), .SHIFT(0), .DEN_BITS(W), .QUO_BITS(SW),
        .SIDE_BITS($bits(t_sr))
    ) u_div_r (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(r10_valid), .i_num(r10_prod), .i_den(r10_r), .i_bypass(1'b0),
        .i_side(dr_in), .o_valid(dr_valid), .o_quo(dr_quo), .o_side(dr_sd)
    );

    assign dh_in = '{w: dr_sd.w, s: dr_sd.s, gneg: dr_sd.gneg, gen: dr_sd.gen,
                     bad: dr_sd.bad};

    sphk_div #(
        .NUM_BITS(SW), .SHIFT(F), .DEN_BITS(W), .QUO_BITS(W),
        .SIDE_BITS($bits(t_sh))
    ) u_div_h (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(dr_valid), .i_num(dr_quo), .i_den(dr_sd.h), .i_bypass(1'b0),
        .i_side(dh_in), .o_valid(dh_valid), .o_quo(dh_quo), .o_side(dh_sd)
    );

    // result item
    t_out n_res;

    always_comb begin
        n_res.kernel_value  = dh_sd.w;
        n_res.kernel_slope  = dh_sd.s;
        n_res.gradient_part = dh_sd.gen
                              ? f_sat(dh_sd.gneg && (dh_quo != '0), LW'(dh_quo)) : '0;
        n_res.bad_length    = dh_sd.bad;
    end

    // output register with one-entry skid
    t_out r_out, r_skid, n_out, n_skid;
    logic r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;
    logic w_pop, w_push;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_pop   = r_out_valid && !i_stall;
    assign w_push  = w_en && dh_valid;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        priority if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = n_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = n_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // checks
    `SPHK_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SPHK_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_stall, !r_skid_valid)
    `SPHK_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_valid && o_data.bad_length,
        (o_data.kernel_value == '0) && (o_data.kernel_slope == '0) && (o_data.gradient_part == '0))
    `SPHK_ASSERT_NOW(a_grad_needs_slope, i_clk, i_rst_n, o_valid && (o_data.gradient_part != '0),
        o_data.kernel_slope != '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_sph_cubic_spline_kernel.sv =====
// Self-checking testbench for sph_cubic_spline_kernel: directed and random pair items
// with a bit-exact kernel predictor, random idling on both sides. Depends on sphk_pkg and sph_cubic_spline_kernel.
module tb_sph_cubic_spline_kernel;
    timeunit 1ns;
    timeprecision 1ps;
    import sphk_pkg::*;

    localparam int                LATENCY    = 409;
    localparam int                DRAIN_WAIT = LATENCY + 20;
    localparam longint            CYCLE_CAP  = 600000;
    localparam longint unsigned   SCALE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned   MIN_WORD   = 64'h8000_0000;
    localparam int                FB         = FRAC_BITS_DEF;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    t_in                      i_data;
    logic                     o_valid;
    logic                     i_stall;
    t_out                     o_data;

    sph_cubic_spline_kernel i_dut (.*);

    // predictor copy of the registers
    logic [DIM_BITS-1:0]  dims_reg;
    logic [NORM_BITS-1:0] norm_reg [3];

    t_out   kernel_results_due[$];
    int     mismatch_count;
    int     gap_pct;
    int     stall_pct;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DIMENSIONS;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        cycle_count = 0;
        dims_reg = DIMS_RESET;
        norm_reg[0] = NORM_1D_RESET;
        norm_reg[1] = NORM_2D_RESET;
        norm_reg[2] = NORM_3D_RESET;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned div_capped(logic [191:0] num, longint unsigned den,
                                                   longint unsigned cap);
        logic [191:0] quo;
        quo = num / {128'd0, den};
        return (quo > {128'd0, cap}) ? cap : quo[63:0];
    endfunction

    function automatic logic [31:0] sat_word(bit neg, longint unsigned mag);
        logic [63:0] m;
        m = mag;
        if (neg) begin
            if (m > MIN_WORD) m = MIN_WORD;
            return -m[31:0];
        end
        if (m > MIN_WORD - 1) m = MIN_WORD - 1;
        return m[31:0];
    endfunction

    function automatic logic [31:0] apply_scale(longint unsigned s, longint signed p);
        bit              neg;
        longint unsigned mag;
        logic [127:0]    prod;
        longint unsigned v;
        neg = p < 0;
        mag = neg ? -p : p;
        prod = {64'd0, s} * {64'd0, mag};
        if (prod[127:96] != 0) v = MIN_WORD;
        else v = prod[95:32];
        return sat_word(neg, v);
    endfunction

    function automatic t_out predict_kernel(t_in x);
        t_out            res;
        longint unsigned r, h, s, q, t, t2, t3, smag, dmag, tq, g;
        longint signed   p4, s4;
        int              dsel;
        bit              sneg, dneg;
        logic [31:0]     ba, bb;
        res = '0;
        r = x.distance;
        h = x.smoothing_length;
        if (h == 0) begin
            res.bad_length = 1'b1;
            return res;
        end
        dsel = (dims_reg == 0) ? 1 : dims_reg;
        s = norm_reg[dsel-1];
        for (int k = 0; k < dsel; k++)
            s = div_capped({128'd0, s} << FB, h, SCALE_MAX);
        if (r < 2 * h) begin
            q = div_capped({128'd0, r} << FB, h, SCALE_MAX);
            if (r >= h) begin
                t = (64'd2 << FB) - q;
                t2 = (t * t) >> FB;
                t3 = (t2 * t) >> FB;
                p4 = t3;
                s4 = -3 * longint'(t2);
            end else begin
                t2 = (q * q) >> FB;
                t3 = (t2 * q) >> FB;
                p4 = 4 * (longint'(1) << FB) - 6 * longint'(t2) + 3 * longint'(t3);
                s4 = 9 * longint'(t2) - 12 * longint'(q);
            end
            res.kernel_value = apply_scale(s, p4);
            if (r != 0) res.kernel_slope = apply_scale(s, s4);
        end
        // gradient from the saturated slope
        if (r != 0 && res.kernel_slope != 0) begin
            sneg = res.kernel_slope[31];
            smag = sneg ? {32'd0, -res.kernel_slope} : {32'd0, res.kernel_slope};
            if (smag == 0) smag = MIN_WORD;
            ba = x.coord_self ^ 32'h8000_0000;
            bb = x.coord_other ^ 32'h8000_0000;
            dneg = ba < bb;
            dmag = dneg ? bb - ba : ba - bb;
            tq = div_capped({128'd0, smag * dmag}, r, SCALE_MAX);
            g = div_capped({128'd0, tq} << FB, h, MIN_WORD);
            res.gradient_part = sat_word(sneg != dneg && g != 0, g);
        end
        return res;
    endfunction

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (kernel_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item %h", o_data);
            end else begin
                t_out want;
                want = kernel_results_due.pop_front();
                if (o_data.kernel_value !== want.kernel_value
                    || o_data.kernel_slope !== want.kernel_slope
                    || o_data.gradient_part !== want.gradient_part
                    || o_data.bad_length !== want.bad_length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: W %h/%h dW %h/%h grad %h/%h bad %b/%b (exp/act)",
                                 want.kernel_value, o_data.kernel_value,
                                 want.kernel_slope, o_data.kernel_slope,
                                 want.gradient_part, o_data.gradient_part,
                                 want.bad_length, o_data.bad_length);
                end
            end
        end
    end

    // ---------------- driver tasks ----------------
    task automatic send_pair(t_in x);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        do @(posedge i_clk); while (o_stall);
        kernel_results_due.push_back(predict_kernel(x));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (kernel_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // write all four registers back to back, block idle
    task automatic load_regs(logic [1:0] d, logic [31:0] f1, logic [31:0] f2, logic [31:0] f3);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DIMENSIONS;
        i_cfg_data <= {30'd0, d};
        @(posedge i_clk);
        dims_reg = d;
        i_cfg_idx <= CFG_NORM_1D;
        i_cfg_data <= f1;
        @(posedge i_clk);
        norm_reg[0] = f1;
        i_cfg_idx <= CFG_NORM_2D;
        i_cfg_data <= f2;
        @(posedge i_clk);
        norm_reg[1] = f2;
        i_cfg_idx <= CFG_NORM_3D;
        i_cfg_data <= f3;
        @(posedge i_clk);
        norm_reg[2] = f3;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in make_pair(int region, longint unsigned h);
        t_in x;
        x.smoothing_length = h[31:0];
        case (region)
            0: x.distance = 0;
            1: x.distance = (h == 0) ? $urandom : $urandom_range(0, h - 1);
            2: x.distance = (2 * h - 1 > 64'hFFFF_FFFF) ? h[31:0] + $urandom_range(0, 65535)
                          : h + longint'($urandom) % h;
            3: x.distance = (2 * h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 2 * h;
            default: x.distance = $urandom;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            x.coord_self = $urandom;
            x.coord_other = $urandom;
        end else begin
            x.coord_self = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            x.coord_other = x.coord_self + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
        end
        return x;
    endfunction

    function automatic longint unsigned rand_length();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 255);
            1: return $urandom_range(32'h0000_4000, 32'h0004_0000);
            2: return $urandom_range(32'h0004_0000, 32'h0100_0000);
            3: return $urandom;
            4: return $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            default: return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 32'h0002_0000);
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        t_in x;
        logic [31:0] one;
        one = 32'h0001_0000;
        x = '{distance: one, smoothing_length: 0, coord_self: 5, coord_other: 1};
        send_pair(x);
        x = '{distance: 0, smoothing_length: one, coord_self: 0, coord_other: 0};
        send_pair(x);
        x = '{distance: one, smoothing_length: one, coord_self: one, coord_other: 0};
        send_pair(x);
        x = '{distance: 2 * one - 1, smoothing_length: one, coord_self: 0, coord_other: one};
        send_pair(x);
        x = '{distance: 2 * one, smoothing_length: one, coord_self: 3, coord_other: 0};
        send_pair(x);
        x = '{distance: one / 2, smoothing_length: one, coord_self: 32'sh7FFF_FFFF,
              coord_other: 32'sh8000_0000};
        send_pair(x);
        x = '{distance: 1, smoothing_length: 1, coord_self: 32'sh8000_0000,
              coord_other: 32'sh7FFF_FFFF};
        send_pair(x);
        x = '{distance: 1, smoothing_length: 3, coord_self: 32'sh7FFF_FFFF, coord_other: 0};
        send_pair(x);
        x = '{distance: 32'hFFFF_FFFF, smoothing_length: 32'hFFFF_FFFF, coord_self: -1,
              coord_other: 0};
        send_pair(x);
        x = '{distance: 32'hFFFF_FFFE, smoothing_length: 32'hFFFF_FFFF, coord_self: 0,
              coord_other: 0};
        send_pair(x);
        x = '{distance: 32'hFFFF_FFFF, smoothing_length: 32'h8000_0000, coord_self: 7,
              coord_other: -7};
        send_pair(x);
        x = '{distance: 0, smoothing_length: 0, coord_self: 0, coord_other: 0};
        send_pair(x);
        x = '{distance: 32'hFFFF_FFFF, smoothing_length: 0, coord_self: -1, coord_other: -1};
        send_pair(x);
        x = '{distance: 100, smoothing_length: 64, coord_self: -100, coord_other: 0};
        send_pair(x);
        wait_drain();
    endtask

    task automatic test_dimension_settings();
        // dimension zero falls back to the one-dimensional factor
        load_regs(2'd0, 32'hFFFF_FFFF, 0, 0);
        repeat (12) send_pair(make_pair($urandom_range(0, 4), rand_length()));
        wait_drain();
        load_regs(2'd1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (12) send_pair(make_pair($urandom_range(0, 4), rand_length()));
        wait_drain();
    endtask

    task automatic test_random_pairs();
        logic [31:0] f [3];
        logic [1:0]  d;
        for (int ph = 0; ph < 6; ph++) begin
            d = (ph % 3) + 1;
            for (int k = 0; k < 3; k++)
                f[k] = (ph == 4) ? 32'hFFFF_FFFF : (ph == 5) ? $urandom : $urandom_range(1 << 26,
                                                                                     1 << 31);
            if (ph == 0) begin
                f[0] = NORM_1D_RESET;
                f[1] = NORM_2D_RESET;
                f[2] = NORM_3D_RESET;
            end
            load_regs(d, f[0], f[1], f[2]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            for (int n = 0; n < 135; n++) begin
                if (ph == 2 && n == 60) begin
                    // sender holds off until the pipe is empty
                    i_valid <= 1'b0;
                    while (kernel_results_due.size() != 0) @(posedge i_clk);
                end
                send_pair(make_pair($urandom_range(0, 5), rand_length()));
            end
            wait_drain();
            gap_pct = 0;
            stall_pct = 0;
        end
        load_regs(DIMS_RESET, NORM_1D_RESET, NORM_2D_RESET, NORM_3D_RESET);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_dimension_settings();
        test_random_pairs();
        wait_drain();
        if (mismatch_count == 0 && kernel_results_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
